/* design/gcls_pkg.sv */
// Package for the cycle-length spectrum block: shared widths, constants,
// the controller state type and the command and status bundles.
// No dependencies; every other design file imports it.
package gcls_pkg;

    // Field widths fixed by the interface.
    localparam int ROW_W     = 12;
    localparam int IDX_W     = 4;
    localparam int VCOUNT_W  = 4;
    localparam int SPEC_W    = 13;

    // Shortest cycle that is reported.
    localparam int MIN_CYCLE = 3;

    // Default vertex capacity and the reset value of the vertex count.
    localparam int MAX_VERTICES_DEF    = 12;
    localparam int VERTEX_COUNT_RESET  = 12;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_MASK_RD,
        ST_MASK_EVAL,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic store_row;
        logic pass_start;
        logic seed;
        logic mask_read;
        logic mask_eval;
        logic upd_read;
        logic upd_write;
        logic mask_next;
        logic s_next;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic n_zero;
        logic mask_done;
        logic s_done;
        logic u_zero;
        logic pend_last;
        logic pend_zero;
    } status_t;

endpackage

/* design/gcls_dp.sv */
// Datapath of the cycle-length spectrum block: adjacency rows, the reach
// table memory, mask and start-vertex counters and the spectrum accumulator.
// Depends on gcls_pkg; driven by gcls_ctrl through cmd_t and status_t.
module gcls_dp #(
    parameter int MAX_VERTICES = gcls_pkg::MAX_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gcls_pkg::cmd_t                cmd,
    output gcls_pkg::status_t             status,
    input  logic                          cfg_wr_en,
    input  logic [gcls_pkg::VCOUNT_W-1:0] cfg_wr_data,
    input  logic [gcls_pkg::IDX_W-1:0]    row_index,
    input  logic [gcls_pkg::ROW_W-1:0]    row_bits,
    output logic [gcls_pkg::SPEC_W-1:0]   spectrum
);
    import gcls_pkg::*;

    localparam int VW    = MAX_VERTICES;
    localparam int AW    = $clog2(VW);
    localparam int SW    = $clog2(VW);
    localparam int NW    = $clog2(VW + 1);
    localparam int DEPTH = 1 << VW;

    // Adjacency rows, held in flip-flops and all read in parallel.
    logic [ROW_W-1:0]    adj_reg [VW];
    logic [VW-1:0]       adj_ext [VW];

    // Reach table: end-vertex mask per vertex mask.
    logic [VW-1:0]       reach_mem [DEPTH];
    logic [VW-1:0]       rd_data_reg;
    logic                mem_we;
    logic [VW-1:0]       mem_waddr;
    logic [VW-1:0]       mem_wdata;
    logic                mem_re;
    logic [VW-1:0]       mem_raddr;

    logic [VCOUNT_W-1:0] vcount_reg;
    logic [VW-1:0]       mask_reg, mask_next;
    logic [SW-1:0]       s_reg, s_next;
    logic [VW-1:0]       pend_reg, pend_next;
    logic [SPEC_W-1:0]   acc_reg, acc_next;
    logic [SPEC_W-1:0]   spec_reg;

    logic [NW-1:0]       n_val;
    logic [VW:0]         full;
    logic [VW-1:0]       full_m1;
    logic [VW-1:0]       s_bit;
    logic [VW-1:0]       allowed;
    logic [VW-1:0]       union_next;
    logic [VW-1:0]       col_s;
    logic [VW-1:0]       pend_low;
    logic [VW-1:0]       target;
    logic [NW-1:0]       len;

    // Effective vertex count, saturated to the capacity.
    always_comb
    begin
        if (int'(vcount_reg) > VW)
            n_val = NW'(VW);
        else
            n_val = NW'(vcount_reg);
    end

    assign full     = (VW + 1)'(1) << n_val;
    assign full_m1  = VW'(full - (VW + 1)'(1));
    assign s_bit    = VW'(1) << s_reg;
    assign allowed  = full_m1 & ~(s_bit - VW'(1));
    assign pend_low = pend_reg & (~pend_reg + VW'(1));
    assign target   = mask_reg | pend_low;
    assign len      = NW'($countones(mask_reg));

    // Rows widened or cut to the vertex capacity.
    always_comb
    begin
        logic [ROW_W+VW-1:0] wide;
        for (int v = 0; v < VW; v++) begin
            wide       = {{VW{1'b0}}, adj_reg[v]};
            adj_ext[v] = wide[VW-1:0];
        end
    end

    // Successors of all path ends in the current entry, and which ends close
    // back to the start vertex.
    always_comb
    begin
        logic [VW-1:0] acc_rows;
        acc_rows = '0;
        for (int v = 0; v < VW; v++) begin
            col_s[v] = adj_ext[v][s_reg];
            if (rd_data_reg[v])
                acc_rows = acc_rows | adj_ext[v];
        end
        union_next = acc_rows & allowed & ~mask_reg;
    end

    // Memory port selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = mask_reg;
        mem_wdata = '0;
        if (cmd.clr_step || cmd.mask_eval) begin
            mem_we    = 1'b1;
            mem_waddr = mask_reg;
            mem_wdata = '0;
        end else if (cmd.seed) begin
            mem_we    = 1'b1;
            mem_waddr = s_bit;
            mem_wdata = s_bit;
        end else if (cmd.upd_write) begin
            mem_we    = 1'b1;
            mem_waddr = target;
            mem_wdata = rd_data_reg | pend_low;
        end
        mem_re    = cmd.mask_read || cmd.upd_read;
        mem_raddr = cmd.upd_read ? target : mask_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            reach_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= reach_mem[mem_raddr];
    end

    // Counter and accumulator updates.
    always_comb
    begin
        mask_next = mask_reg;
        s_next    = s_reg;
        pend_next = pend_reg;
        acc_next  = acc_reg;
        if (cmd.clr_step || cmd.mask_next)
            mask_next = mask_reg + VW'(1);
        else if (cmd.seed)
            mask_next = s_bit;
        if (cmd.pass_start) begin
            s_next   = '0;
            acc_next = '0;
        end else if (cmd.s_next) begin
            s_next = s_reg + SW'(1);
        end
        if (cmd.mask_eval) begin
            pend_next = union_next;
            if (int'(len) >= MIN_CYCLE && int'(len) < SPEC_W && (rd_data_reg & col_s) != '0)
                acc_next = acc_reg | (SPEC_W'(1) << len);
        end else if (cmd.upd_write) begin
            pend_next = pend_reg & ~pend_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mask_reg   <= '0;
            s_reg      <= '0;
            pend_reg   <= '0;
            acc_reg    <= '0;
            vcount_reg <= VCOUNT_W'(VERTEX_COUNT_RESET);
        end else begin
            mask_reg <= mask_next;
            s_reg    <= s_next;
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
            if (cfg_wr_en)
                vcount_reg <= cfg_wr_data;
        end
    end

    // Rows whose index is beyond the capacity are dropped.
    always_ff @(posedge clk)
    begin
        if (cmd.store_row && int'(row_index) < VW)
            adj_reg[row_index[AW-1:0]] <= row_bits;
        if (cmd.out_load)
            spec_reg <= acc_reg;
    end

    assign spectrum = spec_reg;

    assign status.clear_done = (mask_reg == '1);
    assign status.n_zero     = (n_val == '0);
    assign status.mask_done  = (mask_reg == full_m1);
    assign status.s_done     = (NW'(s_reg) + NW'(1) == n_val);
    assign status.u_zero     = (union_next == '0);
    assign status.pend_last  = (pend_reg == pend_low);
    assign status.pend_zero  = (pend_reg == '0);

endmodule

/* design/gcls_ctrl.sv */
// Controller of the cycle-length spectrum block: state machine that runs the
// table clear, row intake, per-start passes and result hand-off.
// Depends on gcls_pkg; drives gcls_dp through cmd_t.
module gcls_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              last_row,
    output logic              out_valid,
    input  logic              out_stall,
    input  gcls_pkg::status_t status,
    output gcls_pkg::cmd_t    cmd,
    output gcls_pkg::state_t  state
);
    import gcls_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_accept;

    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_accept) begin
                    cmd.store_row = 1'b1;
                    if (last_row) begin
                        cmd.pass_start = 1'b1;
                        state_next = status.n_zero ? ST_DONE : ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.seed   = 1'b1;
                state_next = ST_MASK_RD;
            end
            ST_MASK_RD:
            begin
                cmd.mask_read = 1'b1;
                state_next    = ST_MASK_EVAL;
            end
            ST_MASK_EVAL:
            begin
                cmd.mask_eval = 1'b1;
                if (!status.u_zero) begin
                    state_next = ST_UPD_RD;
                end else if (!status.mask_done) begin
                    cmd.mask_next = 1'b1;
                    state_next    = ST_MASK_RD;
                end else if (!status.s_done) begin
                    cmd.s_next = 1'b1;
                    state_next = ST_INIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_UPD_RD:
            begin
                cmd.upd_read = 1'b1;
                state_next   = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                cmd.upd_write = 1'b1;
                if (!status.pend_last) begin
                    state_next = ST_UPD_RD;
                end else if (!status.mask_done) begin
                    cmd.mask_next = 1'b1;
                    state_next    = ST_MASK_RD;
                end else if (!status.s_done) begin
                    cmd.s_next = 1'b1;
                    state_next = ST_INIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.out_load || (out_valid_reg && out_stall);
    end

    assign out_valid = out_valid_reg;
    assign state     = state_reg;

endmodule

/* design/graph_cycle_length_spectrum.sv */
// Cycle-length spectrum of a small graph. Adjacency rows arrive one beat per
// row; a row beat without the last-row flag is only stored. After reset the
// block first clears its 2^MAX_VERTICES-entry reach table, one entry per
// cycle, and stalls input until that is done. A beat flagged as the last row
// starts the computation: for each start vertex s below the vertex count n,
// a seed step, a table read and an evaluate step for every vertex mask from
// 2^s up to 2^n-1, and a read and a write-back for every table update, all
// through the single port pair of the reach-table memory. The spectrum then
// sits in an output register and the next row beat may enter as soon as it
// has been loaded.
//
// The block holds a controller (gcls_ctrl) and a datapath (gcls_dp) joined by
// command and status bundles from gcls_pkg. Bit L of the result is set when a
// cycle with L vertices exists, L from 3 up to 12. Rows are used as given, so
// a directed graph gives its directed cycles. The vertex count register may
// be written only while no computation is running; values above
// MAX_VERTICES are treated as MAX_VERTICES, and fewer than three vertices
// give an empty spectrum. The reach table is kept all zero between passes:
// every entry a pass touches is cleared again when that pass evaluates it.
module graph_cycle_length_spectrum #(
    parameter int MAX_VERTICES = gcls_pkg::MAX_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [gcls_pkg::VCOUNT_W-1:0] cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [gcls_pkg::IDX_W-1:0]    row_index,
    input  logic [gcls_pkg::ROW_W-1:0]    row_bits,
    input  logic                          last_row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gcls_pkg::SPEC_W-1:0]   spectrum
);
    import gcls_pkg::*;

    cmd_t    ctrl_cmd;
    status_t dp_status;
    state_t  ctrl_state;

    // Sequencing of clear, intake, passes and result hand-off.
    gcls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .last_row  (last_row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (dp_status),
        .cmd       (ctrl_cmd),
        .state     (ctrl_state)
    );

    // Row storage, reach table, counters and the spectrum accumulator.
    gcls_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctrl_cmd),
        .status      (dp_status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .row_index   (row_index),
        .row_bits    (row_bits),
        .spectrum    (spectrum)
    );

`ifndef SYNTHESIS
    // A last-row beat always starts work, so input must stall right after it.
    a_last_row_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_row |=> in_stall)
        else $error("input not stalled after last row");

    // Cycles shorter than three vertices are never reported.
    a_short_cycles_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> spectrum[2:0] == 3'b000)
        else $error("spectrum reports a cycle shorter than three");

    // An update step always has a pending target vertex.
    a_update_has_target: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_state == ST_UPD_RD || ctrl_state == ST_UPD_WR |-> !dp_status.pend_zero)
        else $error("table update with no pending target");

    // A result appears only after the controller has finished a computation.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctrl_state == ST_DONE))
        else $error("result raised outside the done state");
`endif

endmodule
